@@ sv/kcc_pkg.sv @@
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared widths, form codes and helpers for the cubic coefficient generator.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int COEFF_WIDTH = 48;
  localparam int INDEX_WIDTH = 16;
  localparam int COUNT_WIDTH = 16;

  // difference of two values, and its magnitude
  localparam int DIFF_W   = VALUE_WIDTH + 1;
  // |dv| * |dt|
  localparam int PROD_W   = 2 * DIFF_W - 1;
  // quotient bits below the saturation point
  localparam int SLOPE_QB = COEFF_WIDTH - 1;
  localparam int HEAD_W   = PROD_W - SLOPE_QB;
  localparam int INV_QB   = VALUE_WIDTH - 1;
  localparam int NUM_W    = 2 * FRAC_BITS + 1;
  localparam int INV_HEAD_W = NUM_W - INV_QB;
  // headroom for a, b, c before saturation
  localparam int EXT_W    = COEFF_WIDTH + 4;

  // dividend of the reciprocal: one in Q(2*FRAC_BITS)
  localparam logic [NUM_W-1:0] INV_NUM = NUM_W'(1) << (2 * FRAC_BITS);

  localparam logic [1:0] FORM_FOUR   = 2'd0;
  localparam logic [1:0] FORM_LEFT   = 2'd1;
  localparam logic [1:0] FORM_RIGHT  = 2'd2;
  localparam logic [1:0] FORM_LINEAR = 2'd3;

  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic [COUNT_WIDTH-1:0] FRAME_COUNT_RST = COUNT_WIDTH'(2);

  function automatic logic signed [COEFF_WIDTH-1:0] sat_coeff(
    input logic signed [EXT_W-1:0] x);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    logic signed [COEFF_WIDTH-1:0] res;
    hi = {{(EXT_W-COEFF_WIDTH+1){1'b0}}, {(COEFF_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (x > hi) begin
      res = hi[COEFF_WIDTH-1:0];
    end else if (x < lo) begin
      res = lo[COEFF_WIDTH-1:0];
    end else begin
      res = x[COEFF_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

@@ sv/kcc_div_step.sv @@
// ----------------------------------------------------------------------------
// kcc_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module kcc_div_step (
  input  logic [kcc_pkg::DIFF_W-1:0] rem,
  input  logic                       din,
  input  logic [kcc_pkg::DIFF_W-1:0] den,
  output logic [kcc_pkg::DIFF_W-1:0] rem_next,
  output logic                       qbit
);
  import kcc_pkg::*;

  logic [DIFF_W+1:0] trial;

  assign trial    = {1'b0, rem, din} - {2'b00, den};
  assign qbit     = ~trial[DIFF_W+1];
  assign rem_next = qbit ? trial[DIFF_W-1:0] : {rem[DIFF_W-2:0], din};

endmodule

@@ sv/keyframe_cubic_coeff_gen.sv @@
// ----------------------------------------------------------------------------
// keyframe_cubic_coeff_gen
// Cubic spline segment coefficients (a, b, c, d), reciprocal span and form.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the 47 stages of the slope dividers (one
//   quotient bit per stage) set the depth. A held output stalls all stages.
// Reset: clears all stage valid bits; frame_count returns to 2.
module keyframe_cubic_coeff_gen (
  input  logic                                 clk,
  input  logic                                 rst,
  // config (APB-style)
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kcc_pkg::INDEX_WIDTH-1:0]      segment_index,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] time_left,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] time_start,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] time_end,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] time_right,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] value_left,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] value_start,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] value_end,
  input  logic signed [kcc_pkg::VALUE_WIDTH-1:0] value_right,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [kcc_pkg::COEFF_WIDTH-1:0] coeff_cubic,
  output logic signed [kcc_pkg::COEFF_WIDTH-1:0] coeff_square,
  output logic signed [kcc_pkg::COEFF_WIDTH-1:0] coeff_linear,
  output logic signed [kcc_pkg::VALUE_WIDTH-1:0] coeff_const,
  output logic signed [kcc_pkg::VALUE_WIDTH-1:0] inverse_span,
  output logic [1:0]                           form_used,
  output logic                                 zero_span
);
  import kcc_pkg::*;

  // divider pipeline record
  typedef struct packed {
    logic [DIFF_W-1:0]   r1;
    logic [DIFF_W-1:0]   d1;
    logic [SLOPE_QB-1:0] q1;
    logic [SLOPE_QB-1:0] lo1;
    logic                ovf1;
    logic                neg1;
    logic                use1;
    logic [DIFF_W-1:0]   r2;
    logic [DIFF_W-1:0]   d2;
    logic [SLOPE_QB-1:0] q2;
    logic [SLOPE_QB-1:0] lo2;
    logic                ovf2;
    logic                neg2;
    logic                use2;
    logic [DIFF_W-1:0]   ri;
    logic [DIFF_W-1:0]   di;
    logic [INV_QB-1:0]   qi;
    logic                ovfi;
    logic                negi;
    logic                zeroi;
    logic                zero;
    logic [1:0]          form;
    logic signed [DIFF_W-1:0]      dv;
    logic signed [VALUE_WIDTH-1:0] v1;
  } div_t;

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] x);
    return x[DIFF_W-1] ? DIFF_W'(-x) : DIFF_W'(x);
  endfunction

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [VALUE_WIDTH-1:0] x);
    return {x[VALUE_WIDTH-1], x};
  endfunction

  function automatic logic signed [EXT_W-1:0] ext_c(
    input logic signed [COEFF_WIDTH-1:0] x);
    return {{(EXT_W-COEFF_WIDTH){x[COEFF_WIDTH-1]}}, x};
  endfunction

  function automatic logic signed [EXT_W-1:0] ext_d(input logic signed [DIFF_W-1:0] x);
    return {{(EXT_W-DIFF_W){x[DIFF_W-1]}}, x};
  endfunction

  // ---------------------------------------------------------------- config
  logic [COUNT_WIDTH-1:0] frame_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT) begin
      frame_count <= pwdata[COUNT_WIDTH-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? {{(32-COUNT_WIDTH){1'b0}}, frame_count}
                                                : 32'd0;

  // ---------------------------------------------------------------- stall
  // Whole pipe advances together; the output register holds while stalled.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- stage A
  // form select and all time / value differences
  logic has_left_in;
  logic has_right_in;
  logic [1:0] form_in;

  assign has_left_in  = segment_index > INDEX_WIDTH'(1);
  assign has_right_in = ({1'b0, segment_index} + (INDEX_WIDTH+1)'(2))
                        < {1'b0, frame_count};

  always_comb begin
    if (has_left_in && has_right_in) begin
      form_in = FORM_FOUR;
    end else if (has_left_in) begin
      form_in = FORM_LEFT;
    end else if (has_right_in) begin
      form_in = FORM_RIGHT;
    end else begin
      form_in = FORM_LINEAR;
    end
  end

  logic va;
  logic [1:0] a_form;
  logic signed [DIFF_W-1:0] a_dt, a_dv, a_dvl, a_dtl, a_dvr, a_dtr;
  logic signed [VALUE_WIDTH-1:0] a_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_form <= form_in;
      a_dt   <= sx(time_end) - sx(time_start);
      a_dv   <= sx(value_end) - sx(value_start);
      a_dvl  <= sx(value_end) - sx(value_left);
      a_dtl  <= sx(time_end) - sx(time_left);
      a_dvr  <= sx(value_right) - sx(value_start);
      a_dtr  <= sx(time_right) - sx(time_start);
      a_v1   <= value_start;
    end
  end

  // ---------------------------------------------------------------- stage B
  // magnitudes, signs, products dv * dt, divisor-zero checks
  logic a_left, a_right;
  assign a_left  = (a_form == FORM_FOUR) || (a_form == FORM_LEFT);
  assign a_right = (a_form == FORM_FOUR) || (a_form == FORM_RIGHT);

  logic vb;
  logic [PROD_W-1:0] b_p1, b_p2;
  logic [DIFF_W-1:0] b_d1, b_d2, b_di;
  logic b_neg1, b_neg2, b_negi, b_use1, b_use2, b_zeroi, b_zero;
  logic [1:0] b_form;
  logic signed [DIFF_W-1:0] b_dv;
  logic signed [VALUE_WIDTH-1:0] b_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_p1    <= PROD_W'(mag(a_dvl)) * PROD_W'(mag(a_dt));
      b_p2    <= PROD_W'(mag(a_dvr)) * PROD_W'(mag(a_dt));
      b_d1    <= mag(a_dtl);
      b_d2    <= mag(a_dtr);
      b_di    <= mag(a_dt);
      b_neg1  <= a_dvl[DIFF_W-1] ^ a_dt[DIFF_W-1] ^ a_dtl[DIFF_W-1];
      b_neg2  <= a_dvr[DIFF_W-1] ^ a_dt[DIFF_W-1] ^ a_dtr[DIFF_W-1];
      b_negi  <= a_dt[DIFF_W-1];
      b_use1  <= a_left && (a_dtl != '0);
      b_use2  <= a_right && (a_dtr != '0);
      b_zeroi <= (a_dt == '0);
      b_zero  <= (a_dt == '0) || (a_left && a_dtl == '0) || (a_right && a_dtr == '0);
      b_form  <= a_form;
      b_dv    <= a_dv;
      b_v1    <= a_v1;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Divider setup. A quotient at or above the saturation point shows up as
  // the top dividend bits already reaching the divisor.
  logic [HEAD_W-1:0]     head1, head2;
  logic [INV_HEAD_W-1:0] headi;
  div_t c_nx;

  assign head1 = b_p1[PROD_W-1 -: HEAD_W];
  assign head2 = b_p2[PROD_W-1 -: HEAD_W];
  assign headi = INV_NUM[NUM_W-1 -: INV_HEAD_W];

  always_comb begin
    c_nx.r1    = DIFF_W'(head1);
    c_nx.d1    = b_d1;
    c_nx.q1    = '0;
    c_nx.lo1   = b_p1[SLOPE_QB-1:0];
    c_nx.ovf1  = DIFF_W'(head1) >= b_d1;
    c_nx.neg1  = b_neg1;
    c_nx.use1  = b_use1;
    c_nx.r2    = DIFF_W'(head2);
    c_nx.d2    = b_d2;
    c_nx.q2    = '0;
    c_nx.lo2   = b_p2[SLOPE_QB-1:0];
    c_nx.ovf2  = DIFF_W'(head2) >= b_d2;
    c_nx.neg2  = b_neg2;
    c_nx.use2  = b_use2;
    c_nx.ri    = DIFF_W'(headi);
    c_nx.di    = b_di;
    c_nx.qi    = '0;
    c_nx.ovfi  = DIFF_W'(headi) >= b_di;
    c_nx.negi  = b_negi;
    c_nx.zeroi = b_zeroi;
    c_nx.zero  = b_zero;
    c_nx.form  = b_form;
    c_nx.dv    = b_dv;
    c_nx.v1    = b_v1;
  end

  div_t dp [0:SLOPE_QB];
  logic [SLOPE_QB:0] vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp[0] <= 1'b0;
    end else if (en) begin
      vp[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0] <= c_nx;
    end
  end

  // ---------------------------------------------------------------- dividers
  // One quotient bit per stage for both slopes; the reciprocal runs in the
  // first INV_QB stages and then rides along.
  for (genvar k = 0; k < SLOPE_QB; k++) begin : g_div
    localparam bit InvAct = (k < INV_QB);
    localparam int InvIdx = InvAct ? (INV_QB - 1 - k) : 0;

    logic [DIFF_W-1:0] r1n, r2n, rin;
    logic q1b, q2b, qib;
    div_t nx;

    kcc_div_step u_step1 (
      .rem(dp[k].r1), .din(dp[k].lo1[SLOPE_QB-1]), .den(dp[k].d1),
      .rem_next(r1n), .qbit(q1b)
    );
    kcc_div_step u_step2 (
      .rem(dp[k].r2), .din(dp[k].lo2[SLOPE_QB-1]), .den(dp[k].d2),
      .rem_next(r2n), .qbit(q2b)
    );
    kcc_div_step u_stepi (
      .rem(dp[k].ri), .din(INV_NUM[InvIdx]), .den(dp[k].di),
      .rem_next(rin), .qbit(qib)
    );

    always_comb begin
      nx     = dp[k];
      nx.r1  = r1n;
      nx.q1  = {dp[k].q1[SLOPE_QB-2:0], q1b};
      nx.lo1 = {dp[k].lo1[SLOPE_QB-2:0], 1'b0};
      nx.r2  = r2n;
      nx.q2  = {dp[k].q2[SLOPE_QB-2:0], q2b};
      nx.lo2 = {dp[k].lo2[SLOPE_QB-2:0], 1'b0};
      if (InvAct) begin
        nx.ri = rin;
        nx.qi = {dp[k].qi[INV_QB-2:0], qib};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vp[k+1] <= 1'b0;
      end else if (en) begin
        vp[k+1] <= vp[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dp[k+1] <= nx;
      end
    end
  end

  // ---------------------------------------------------------------- stage F1
  // signed, saturated slopes; reciprocal; exact cubic term a
  div_t e;
  assign e = dp[SLOPE_QB];

  logic signed [COEFF_WIDTH-1:0] s1_nx, s2_nx;
  logic signed [VALUE_WIDTH-1:0] inv_nx;
  logic signed [EXT_W-1:0]       a_nx;
  logic signed [COEFF_WIDTH-1:0] cmax;
  logic signed [VALUE_WIDTH-1:0] vmax;

  assign cmax = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
  assign vmax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  always_comb begin
    if (!e.use1) begin
      s1_nx = '0;
    end else if (e.ovf1) begin
      s1_nx = e.neg1 ? ~cmax : cmax;
    end else begin
      s1_nx = e.neg1 ? -COEFF_WIDTH'(e.q1) : COEFF_WIDTH'(e.q1);
    end
    if (!e.use2) begin
      s2_nx = '0;
    end else if (e.ovf2) begin
      s2_nx = e.neg2 ? ~cmax : cmax;
    end else begin
      s2_nx = e.neg2 ? -COEFF_WIDTH'(e.q2) : COEFF_WIDTH'(e.q2);
    end
    if (e.zeroi) begin
      inv_nx = '0;
    end else if (e.ovfi) begin
      inv_nx = e.negi ? ~vmax : vmax;
    end else begin
      inv_nx = e.negi ? -VALUE_WIDTH'(e.qi) : VALUE_WIDTH'(e.qi);
    end
    if (e.form == FORM_FOUR) begin
      a_nx = ext_c(s1_nx) + ext_c(s2_nx) - (ext_d(e.dv) <<< 1);
    end else begin
      a_nx = '0;
    end
  end

  logic vf;
  logic signed [COEFF_WIDTH-1:0] f_s1, f_s2;
  logic signed [EXT_W-1:0]       f_a;
  logic signed [VALUE_WIDTH-1:0] f_inv, f_v1;
  logic signed [DIFF_W-1:0]      f_dv;
  logic [1:0] f_form;
  logic f_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vp[SLOPE_QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_s1   <= s1_nx;
      f_s2   <= s2_nx;
      f_a    <= a_nx;
      f_inv  <= inv_nx;
      f_v1   <= e.v1;
      f_dv   <= e.dv;
      f_form <= e.form;
      f_zero <= e.zero;
    end
  end

  // ---------------------------------------------------------------- stage F2
  // b and c per form, saturate, output register
  logic signed [EXT_W-1:0] b_x, c_x;

  always_comb begin
    case (f_form)
      FORM_FOUR: begin
        b_x = ext_d(f_dv) - f_a - ext_c(f_s1);
        c_x = ext_c(f_s1);
      end
      FORM_LEFT: begin
        b_x = ext_d(f_dv) - ext_c(f_s1);
        c_x = ext_c(f_s1);
      end
      FORM_RIGHT: begin
        b_x = ext_c(f_s2) - ext_d(f_dv);
        c_x = (ext_d(f_dv) <<< 1) - ext_c(f_s2);
      end
      default: begin
        b_x = '0;
        c_x = ext_d(f_dv);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coeff_cubic  <= sat_coeff(f_a);
      coeff_square <= sat_coeff(b_x);
      coeff_linear <= sat_coeff(c_x);
      coeff_const  <= f_v1;
      inverse_span <= f_inv;
      form_used    <= f_form;
      zero_span    <= f_zero;
    end
  end

endmodule

@@ sv/kcc_checker.sv @@
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks for keyframe_cubic_coeff_gen, attached by bind.
// ----------------------------------------------------------------------------
module kcc_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [kcc_pkg::COEFF_WIDTH-1:0] coeff_cubic,
  input logic signed [kcc_pkg::COEFF_WIDTH-1:0] coeff_square,
  input logic signed [kcc_pkg::VALUE_WIDTH-1:0] inverse_span,
  input logic [1:0]                             form_used,
  input logic                                   zero_span
);
  import kcc_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coeff_square) && $stable(form_used))
    else $error("result changed while stalled");

  // empty output side never blocks input
  a_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no pending result");

  // linear form carries no higher terms
  a_linear: assert property (@(posedge clk) disable iff (rst)
    out_valid && form_used == FORM_LINEAR |-> coeff_cubic == '0 && coeff_square == '0)
    else $error("linear form with nonzero a or b");

  // three-point forms are quadratic
  a_quad: assert property (@(posedge clk) disable iff (rst)
    out_valid && (form_used == FORM_LEFT || form_used == FORM_RIGHT) |-> coeff_cubic == '0)
    else $error("three-point form with nonzero a");

  // reciprocal is zero only for a zero span
  a_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && inverse_span == '0 |-> zero_span)
    else $error("zero reciprocal without flag");

endmodule

bind keyframe_cubic_coeff_gen kcc_checker u_kcc_checker (.*);

@@ verif/keyframe_cubic_coeff_gen_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyframe_cubic_coeff_gen_test
// Self-checking bench for the cubic spline segment coefficient generator.
// Drives directed and random segment items over valid/ready with random
// idling on both sides, programs frame_count over APB between phases, and
// compares every result against an in-bench bit-accurate predictor.
// ----------------------------------------------------------------------------
module keyframe_cubic_coeff_gen_test;
  import kcc_pkg::*;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] idx;
    logic signed [VALUE_WIDTH-1:0] t_l, t_s, t_e, t_r, v_l, v_s, v_e, v_r;
  } seg_item_t;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] a, b, c;
    logic signed [VALUE_WIDTH-1:0] d, inv;
    logic [1:0] form;
    logic zero;
  } coeff_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [INDEX_WIDTH-1:0] segment_index = '0;
  logic signed [VALUE_WIDTH-1:0] time_left = '0, time_start = '0, time_end = '0;
  logic signed [VALUE_WIDTH-1:0] time_right = '0, value_left = '0, value_start = '0;
  logic signed [VALUE_WIDTH-1:0] value_end = '0, value_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEFF_WIDTH-1:0] coeff_cubic, coeff_square, coeff_linear;
  logic signed [VALUE_WIDTH-1:0] coeff_const, inverse_span;
  logic [1:0] form_used;
  logic zero_span;

  keyframe_cubic_coeff_gen dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the frame_count register
  logic [COUNT_WIDTH-1:0] frames_setting = FRAME_COUNT_RST;
  coeff_set_t pending_coeffs[$];
  int errors = 0;
  // idle odds, percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // trunc(num/den) on magnitudes, saturated to 48-bit signed
  function automatic logic signed [COEFF_WIDTH-1:0] slope_of(
      longint dv, longint dt, longint den, ref logic zero);
    logic [127:0] num, q;
    logic [63:0] d;
    logic neg;
    logic [COEFF_WIDTH-1:0] cap;
    if (den == 0) begin
      zero = 1'b1;
      return '0;
    end
    neg = ((dv < 0) != (dt < 0)) != (den < 0);
    num = 128'(dv < 0 ? -dv : dv) * 128'(dt < 0 ? -dt : dt);
    d = den < 0 ? -den : den;
    q = num / d;
    cap = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
    if (q > 128'(cap)) return neg ? -$signed({1'b0, cap}) - 1 : $signed({1'b0, cap});
    return neg ? -$signed(q[COEFF_WIDTH-1:0]) : $signed(q[COEFF_WIDTH-1:0]);
  endfunction

  function automatic logic signed [COEFF_WIDTH-1:0] clip48(longint x);
    longint hi;
    hi = (64'sd1 <<< (COEFF_WIDTH-1)) - 1;
    if (x > hi) return hi[COEFF_WIDTH-1:0];
    if (x < -hi - 1) return 48'sh800000000000;
    return x[COEFF_WIDTH-1:0];
  endfunction

  function automatic coeff_set_t predict_coeffs(seg_item_t it);
    coeff_set_t r;
    longint dt, dv, s1, s2, a, b, c;
    logic [63:0] q;
    logic zero;
    logic has_l, has_r;
    zero = 1'b0;
    s1 = 0; s2 = 0; a = 0; b = 0; c = 0;
    dt = longint'(it.t_e) - longint'(it.t_s);
    dv = longint'(it.v_e) - longint'(it.v_s);
    r.inv = '0;
    if (dt == 0) begin
      zero = 1'b1;
    end else begin
      q = (64'd1 << (2*FRAC_BITS)) / (dt < 0 ? -dt : dt);
      if (q >= 64'h8000_0000) r.inv = dt < 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else r.inv = dt < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
    end
    has_l = it.idx > 1;
    has_r = (32'(it.idx) + 2) < 32'(frames_setting);
    if (has_l) s1 = slope_of(longint'(it.v_e) - it.v_l, dt,
                             longint'(it.t_e) - it.t_l, zero);
    if (has_r) s2 = slope_of(longint'(it.v_r) - it.v_s, dt,
                             longint'(it.t_r) - it.t_s, zero);
    if (has_l && has_r) begin
      r.form = FORM_FOUR;
      a = s1 + s2 - 2*dv; b = dv - a - s1; c = s1;
    end else if (has_l) begin
      r.form = FORM_LEFT;
      b = dv - s1; c = s1;
    end else if (has_r) begin
      r.form = FORM_RIGHT;
      b = s2 - dv; c = dv - b;
    end else begin
      r.form = FORM_LINEAR;
      c = dv;
    end
    r.a = clip48(a); r.b = clip48(b); r.c = clip48(c);
    r.d = it.v_s;
    r.zero = zero;
    return r;
  endfunction

  // drive one item and hold it until the transfer; valid drops only when
  // the sender idles or drains
  task automatic send_item(seg_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    segment_index <= it.idx;
    time_left <= it.t_l; time_start <= it.t_s;
    time_end <= it.t_e; time_right <= it.t_r;
    value_left <= it.v_l; value_start <= it.v_s;
    value_end <= it.v_e; value_right <= it.v_r;
    do @(posedge clk); while (!in_ready);
    pending_coeffs.push_back(predict_coeffs(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [COUNT_WIDTH-1:0] val);
    drain_results();
    // no result without an item, but let the pipe settle anyway
    repeat (60) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_FRAME_COUNT) << 2; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    frames_setting = val;
  endtask

  // receiver stall pattern and result checker
  always @(posedge clk) begin
    coeff_set_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (pending_coeffs.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_c = pending_coeffs.pop_front();
        if (coeff_cubic !== exp_c.a) begin
          $error("coeff_cubic exp %0d got %0d", exp_c.a, coeff_cubic); errors++;
        end
        if (coeff_square !== exp_c.b) begin
          $error("coeff_square exp %0d got %0d", exp_c.b, coeff_square); errors++;
        end
        if (coeff_linear !== exp_c.c) begin
          $error("coeff_linear exp %0d got %0d", exp_c.c, coeff_linear); errors++;
        end
        if (coeff_const !== exp_c.d) begin
          $error("coeff_const exp %0d got %0d", exp_c.d, coeff_const); errors++;
        end
        if (inverse_span !== exp_c.inv) begin
          $error("inverse_span exp %0d got %0d", exp_c.inv, inverse_span); errors++;
        end
        if (form_used !== exp_c.form) begin
          $error("form_used exp %0d got %0d", exp_c.form, form_used); errors++;
        end
        if (zero_span !== exp_c.zero) begin
          $error("zero_span exp %0d got %0d", exp_c.zero, zero_span); errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(65536*8)) - 32'sd262144);
      default: return $signed($urandom());
    endcase
  endfunction

  // random segment: mostly ordered keyframe times, sometimes full noise
  function automatic seg_item_t rand_segment();
    seg_item_t it;
    int step;
    it.idx = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(6));
    if ($urandom_range(4) != 0) begin
      step = $urandom_range(1, 1 << 20);
      it.t_s = $signed($urandom_range(1 << 24)) - 32'sd8388608;
      it.t_l = it.t_s - $urandom_range(step);
      it.t_e = it.t_s + ($urandom_range(15) == 0 ? 0 : step);
      it.t_r = it.t_e + $urandom_range(step);
      it.v_l = rand_word(); it.v_s = rand_word();
      it.v_e = rand_word(); it.v_r = rand_word();
    end else begin
      it.t_l = rand_word(); it.t_s = rand_word(); it.t_e = rand_word();
      it.t_r = rand_word(); it.v_l = rand_word(); it.v_s = rand_word();
      it.v_e = rand_word(); it.v_r = rand_word();
    end
    return it;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_item(rand_segment());
  endtask

  // extremes, each form, zero spans and slope divisors
  task automatic test_directed();
    seg_item_t it;
    int k;
    for (k = 0; k < 6; k++) begin
      it = '{idx: 16'(k), t_l: -32'sd65536, t_s: 0, t_e: 32'sd65536,
             t_r: 32'sd131072, v_l: 32'sd100, v_s: 32'sd200, v_e: -32'sd300,
             v_r: 32'sd400};
      send_item(it);
    end
    it = '{16'hffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
           32'sh8000_0000};
    send_item(it);
    it.idx = 16'd3; send_item(it);
    it = '{16'd3, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001,
           32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
           32'sh8000_0000};
    send_item(it);
    // zero span, zero left and right divisors
    it = '{16'd3, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd1, 32'sd2, 32'sd3, 32'sd4};
    send_item(it);
    it = '{16'd3, 32'sd9, 32'sd1, 32'sd9, 32'sd1, -32'sd7, 32'sd2, 32'sd3, 32'sd4};
    send_item(it);
    it = '{16'd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, -32'sd1, 32'sd1, 32'sd0};
    send_item(it);
    it = '{16'd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    send_item(it);
    it = '{16'd2, 32'sd0, 32'sd0, 32'sd2, 32'sd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    send_item(it);
  endtask

  task automatic test_flowing();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(250);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 59; recv_stall_pct = 0;
    send_random(200);
    // hold off until the pipe runs dry, then resume
    drain_results();
    send_random(50);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; recv_stall_pct = 59;
    send_random(250);
  endtask

  task automatic test_light_idle();
    send_idle_pct = 7; recv_stall_pct = 7;
    send_random(250);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_frame_count(16'd7);
    test_directed();
    test_flowing();
    write_frame_count(16'hffff);
    test_sender_idle();
    write_frame_count(16'd2);
    test_receiver_stall();
    write_frame_count(16'd5);
    test_light_idle();
    send_idle_pct = 0; recv_stall_pct = 0;
    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
sv/kcc_pkg.sv
sv/kcc_div_step.sv
sv/keyframe_cubic_coeff_gen.sv
sv/kcc_checker.sv
verif/keyframe_cubic_coeff_gen_test.sv
